FILE: src/ppcu_pkg.sv
// ----------------------------------------------------------------------------
// ppcu_pkg
// Shared types and constants for the packed pattern cell unpacker.
// ----------------------------------------------------------------------------
package ppcu_pkg;

    localparam int unsigned DEF_MAX_CHANNELS = 32;
    localparam int unsigned DEF_MAX_ROWS     = 256;

    // cell layout
    localparam logic [4:0] FULL_CELL_MASK   = 5'h1E;
    localparam logic [7:0] NOTE_KEY_OFF_IN  = 8'h61;
    localparam logic [7:0] NOTE_KEY_OFF_OUT = 8'd121;
    localparam logic [7:0] NOTE_OFFSET      = 8'd12;
    localparam logic [7:0] NOTE_BITS        = 8'h7F;

    localparam int unsigned FIELD_NOTE  = 0;
    localparam int unsigned FIELD_INST  = 1;
    localparam int unsigned FIELD_VOL   = 2;
    localparam int unsigned FIELD_EFF   = 3;
    localparam int unsigned FIELD_PARAM = 4;

    // configuration register map
    localparam int unsigned CFG_ADDR_W    = 3;
    localparam logic        REG_CHANNELS  = 1'b0;
    localparam logic        REG_ROWS      = 1'b1;
    localparam logic [5:0]  CHANNELS_RST  = 6'd8;
    localparam logic [8:0]  ROWS_RST      = 9'd64;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] pattern_byte;
    } byte_word_t;

    typedef struct packed {
        logic [7:0] note;
        logic [7:0] instrument;
        logic [7:0] volume;
        logic [7:0] effect;
        logic [7:0] param;
    } cell_raw_t;

    typedef struct packed {
        logic [7:0] note_value;
        logic [7:0] instrument_number;
        logic [7:0] volume_column;
        logic [7:0] effect_type;
        logic [7:0] effect_argument;
        logic [4:0] channel_index;
        logic [7:0] row_index;
        logic       pattern_done;
    } cell_word_t;

    typedef struct packed {
        logic [5:0] channel_count;
        logic [8:0] row_count;
    } cfg_t;

    typedef struct packed {
        logic at_start;
        logic ch_zero;
        logic row_zero;
    } pos_status_t;

endpackage

FILE: src/ppcu_stream_if.sv
// ----------------------------------------------------------------------------
// ppcu_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface ppcu_stream_if #(parameter type T = logic);

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: src/ppcu_front.sv
// ----------------------------------------------------------------------------
// ppcu_front
// Byte parser: tracks the presence mask and assembles one cell per push.
// ----------------------------------------------------------------------------
module ppcu_front
    import ppcu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    ppcu_stream_if.sink      byte_in,
    output logic             push_valid,
    output cell_raw_t        push_data,
    input  logic             push_ready,
    output logic             at_start
);

    logic [4:0] mask_reg,  mask_next;
    logic [7:0] note_reg,  note_next;
    logic [7:0] inst_reg,  inst_next;
    logic [7:0] vol_reg,   vol_next;
    logic [7:0] eff_reg,   eff_next;
    logic [7:0] param_val;
    logic [7:0] b;
    logic       fire;

    assign byte_in.ready = push_ready;
    assign fire          = byte_in.valid && push_ready;
    assign b             = byte_in.data.pattern_byte;
    assign at_start      = (mask_reg == '0);

    always_comb
    begin
        mask_next = mask_reg;
        note_next = note_reg;
        inst_next = inst_reg;
        vol_next  = vol_reg;
        eff_next  = eff_reg;
        param_val = '0;
        if (fire)
        begin
            if (mask_reg == '0)
            begin
                // new cell: drop whatever the last one left
                note_next = '0;
                inst_next = '0;
                vol_next  = '0;
                eff_next  = '0;
                if (b[7])
                begin
                    mask_next = b[4:0];
                end
                else
                begin
                    note_next = b & NOTE_BITS;
                    mask_next = FULL_CELL_MASK;
                end
            end
            else if (mask_reg[FIELD_NOTE])
            begin
                note_next = b;
                mask_next[FIELD_NOTE] = 1'b0;
            end
            else if (mask_reg[FIELD_INST])
            begin
                inst_next = b;
                mask_next[FIELD_INST] = 1'b0;
            end
            else if (mask_reg[FIELD_VOL])
            begin
                vol_next = b;
                mask_next[FIELD_VOL] = 1'b0;
            end
            else if (mask_reg[FIELD_EFF])
            begin
                eff_next = b;
                mask_next[FIELD_EFF] = 1'b0;
            end
            else
            begin
                param_val = b;
                mask_next = '0;
            end
        end
    end

    // cell complete once the mask empties on an accepted byte
    assign push_valid = fire && (mask_next == '0);
    assign push_data  = '{note: note_next, instrument: inst_next, volume: vol_next,
                          effect: eff_next, param: param_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            note_reg <= '0;
            inst_reg <= '0;
            vol_reg  <= '0;
            eff_reg  <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
            note_reg <= note_next;
            inst_reg <= inst_next;
            vol_reg  <= vol_next;
            eff_reg  <= eff_next;
        end
    end

endmodule

FILE: src/ppcu_queue.sv
// ----------------------------------------------------------------------------
// ppcu_queue
// Short FIFO of assembled cells between the parser and the output stage.
// ----------------------------------------------------------------------------
module ppcu_queue
    import ppcu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  cell_raw_t push_data,
    output logic      push_ready,
    output logic      pop_valid,
    output cell_raw_t pop_data,
    input  logic      pop_ready
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    cell_raw_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: src/ppcu_back.sv
// ----------------------------------------------------------------------------
// ppcu_back
// Output stage: remaps the note, stamps channel/row and registers the word.
// ----------------------------------------------------------------------------
module ppcu_back
    import ppcu_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int unsigned MAX_ROWS     = DEF_MAX_ROWS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          pop_valid,
    input  cell_raw_t     pop_data,
    output logic          pop_ready,
    ppcu_stream_if.source cell_out,
    output pos_status_t   pos_status
);

    localparam int unsigned CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [6:0]  MAX_CH_V  = 7'(MAX_CHANNELS);
    localparam logic [9:0]  MAX_ROW_V = 10'(MAX_ROWS);

    logic [CH_W-1:0]  ch_reg,  ch_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             out_valid_reg;
    cell_word_t       out_reg, out_next;
    logic [6:0]       nch, ch_plus;
    logic [9:0]       nrow, row_plus;
    logic             last_ch, last_row, take;
    logic [31:0]      ch_ext, row_ext;

    function automatic logic [7:0] remap_note(input logic [7:0] n);
        logic [7:0] r;
        if (n == NOTE_KEY_OFF_IN)
            r = NOTE_KEY_OFF_OUT;
        else if (n == '0)
            r = '0;
        else
            r = n + NOTE_OFFSET;
        return r;
    endfunction

    assign pop_ready = !out_valid_reg || cell_out.ready;
    assign take      = pop_valid && pop_ready;

    // zero counts act as one, large ones saturate
    assign nch  = ({1'b0, cfg.channel_count} == '0) ? 7'd1 :
                  (({1'b0, cfg.channel_count} > MAX_CH_V) ? MAX_CH_V
                                                          : {1'b0, cfg.channel_count});
    assign nrow = ({1'b0, cfg.row_count} == '0) ? 10'd1 :
                  (({1'b0, cfg.row_count} > MAX_ROW_V) ? MAX_ROW_V
                                                       : {1'b0, cfg.row_count});
    assign ch_plus  = 7'(ch_reg) + 7'd1;
    assign row_plus = 10'(row_reg) + 10'd1;
    assign last_ch  = (ch_plus >= nch);
    assign last_row = (row_plus >= nrow);
    assign ch_ext   = 32'(ch_reg);
    assign row_ext  = 32'(row_reg);

    always_comb
    begin
        ch_next  = ch_reg;
        row_next = row_reg;
        out_next = out_reg;
        if (take)
        begin
            out_next.note_value        = remap_note(pop_data.note);
            out_next.instrument_number = pop_data.instrument;
            out_next.volume_column     = pop_data.volume;
            out_next.effect_type       = pop_data.effect;
            out_next.effect_argument   = pop_data.param;
            out_next.channel_index     = ch_ext[4:0];
            out_next.row_index         = row_ext[7:0];
            out_next.pattern_done      = last_ch && last_row;
            if (last_ch)
            begin
                ch_next  = '0;
                row_next = last_row ? '0 : row_plus[ROW_W-1:0];
            end
            else
            begin
                ch_next = ch_plus[CH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg        <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ch_reg  <= ch_next;
            row_reg <= row_next;
            if (pop_ready)
                out_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign cell_out.valid = out_valid_reg;
    assign cell_out.data  = out_reg;

    assign pos_status.at_start = !out_valid_reg && !pop_valid;
    assign pos_status.ch_zero  = (ch_reg == '0);
    assign pos_status.row_zero = (row_reg == '0);

endmodule

FILE: src/packed_pattern_cell_unpacker.sv
// ----------------------------------------------------------------------------
// packed_pattern_cell_unpacker
// Rebuilds tracker pattern cells from a packed byte stream.
// ----------------------------------------------------------------------------
//  channel   dir  type                  word
//  byte_in   in   valid/ready stream    one packed pattern byte
//  cell_out  out  valid/ready stream    one decoded cell with channel/row
//  apb       in   APB write/read        channel_count @0x0, row_count @0x4
//
//  One byte accepted per cycle while the queue has room; after its last
//  byte a cell passes the parser push, queue and output register.
//  The two-entry cell queue decouples parser and output stage: byte_in.ready
//  drops only when the queue is full, i.e. after cell_out stalls for a while.
//  rst_n clears the parse mask, channel/row position and registers to
//  channel_count 8, row_count 64.
// ----------------------------------------------------------------------------
module packed_pattern_cell_unpacker
    import ppcu_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int unsigned MAX_ROWS     = DEF_MAX_ROWS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    ppcu_stream_if.sink           byte_in,
    ppcu_stream_if.source         cell_out
);

    cfg_t        cfg_reg;
    logic        cfg_wr;
    logic        reg_sel;
    logic        push_valid, push_ready;
    cell_raw_t   push_data;
    logic        pop_valid, pop_ready;
    cell_raw_t   pop_data;
    logic        front_at_start;
    pos_status_t pos_status;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count <= CHANNELS_RST;
            cfg_reg.row_count     <= ROWS_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_CHANNELS: cfg_reg.channel_count <= pwdata[5:0];
                REG_ROWS:     cfg_reg.row_count     <= pwdata[8:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_CHANNELS: prdata = {26'd0, cfg_reg.channel_count};
            REG_ROWS:     prdata = {23'd0, cfg_reg.row_count};
            default:      prdata = '0;
        endcase
    end

    ppcu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .at_start   (front_at_start)
    );

    ppcu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    ppcu_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_ROWS     (MAX_ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready),
        .cell_out   (cell_out),
        .pos_status (pos_status)
    );

    // a cell pushed with no room would be lost
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_ready)
        else $error("cell pushed into full queue");

    // the last cell of a pattern leaves the position at channel 0, row 0
    a_done_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_out.valid && cell_out.data.pattern_done)
            |-> (pos_status.ch_zero && pos_status.row_zero))
        else $error("pattern_done without position wrap");

    // a pushed cell is visible at the queue head on the next cycle when idle
    a_push_flows: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && pos_status.at_start) |=> pop_valid)
        else $error("pushed cell not visible at queue head");

    // a cell that begins and ends on one byte needs a mask byte
    a_single_byte_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && front_at_start) |-> byte_in.data.pattern_byte[7])
        else $error("single-byte cell without mask flag");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packed pattern cell unpacker. Streams packed
// pattern bytes in (directed corners, then mostly well-formed random cells
// with some noise), predicts every decoded cell with its channel, row and
// done flag, and checks each output word in order. Channel and row counts
// are reprogrammed over APB between idle phases, extremes included.
// ----------------------------------------------------------------------------
module tb;
    import ppcu_pkg::*;

    localparam int unsigned PACKED_BIT  = 7;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASE_BYTES = 180;
    localparam int unsigned N_PHASES = 8;

    localparam logic [CFG_ADDR_W-1:0] ADDR_CHANNELS = {REG_CHANNELS, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_ROWS     = {REG_ROWS, 2'b00};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    ppcu_stream_if #(.T(byte_word_t)) byte_if ();
    ppcu_stream_if #(.T(cell_word_t)) cell_if ();

    packed_pattern_cell_unpacker i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .byte_in  (byte_if),
        .cell_out (cell_if)
    );

    always #1 clk = ~clk;

    // pending stimulus and expected cells
    logic [7:0]  bytes_pending [$];
    cell_word_t  cells_due [$];
    int unsigned sent_total  = 0;
    int unsigned taken_total = 0;
    int unsigned cells_seen  = 0;
    int unsigned fails       = 0;
    int unsigned quiet_cycles = 0;
    bit          no_idle     = 1'b0;
    int unsigned send_hold   = 0;
    int unsigned sink_hold   = 0;

    // predictor state
    logic [4:0] parse_mask = '0;
    logic [7:0] cur_note   = '0;
    logic [7:0] cur_inst   = '0;
    logic [7:0] cur_vol    = '0;
    logic [7:0] cur_eff    = '0;
    logic [4:0] chan_pos   = '0;
    logic [7:0] row_pos    = '0;
    logic [5:0] cfg_channels = CHANNELS_RST;
    logic [8:0] cfg_rows     = ROWS_RST;

    logic [7:0] directed_bytes [25] = '{
        8'h7F, 8'hFF, 8'h00, 8'hAA, 8'h55,        // full cell, top note
        8'h80,                                    // empty mask
        8'hE0,                                    // empty mask, bits 5 and 6 set
        8'h9F, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, // all fields, 8-bit note
        8'h81, NOTE_KEY_OFF_IN,                   // key off after mask
        8'h81, 8'hF4,                             // note wraps to zero
        8'h90, 8'hFF,                             // parameter only
        8'h82, 8'h11,
        8'h84, 8'h22,
        8'h88, 8'h33
    };

    function automatic int unsigned eff_count(int unsigned v, int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // advance the parser by one byte; queue a cell when one completes
    task automatic unpack_byte(input logic [7:0] b);
        logic [7:0]  arg;
        cell_word_t  due_word;
        int unsigned nch;
        int unsigned nrow;
        bit          last_ch;
        bit          last_row;
        arg = '0;
        if (parse_mask == '0)
        begin
            cur_note = '0;
            cur_inst = '0;
            cur_vol  = '0;
            cur_eff  = '0;
            if (b[PACKED_BIT])
                parse_mask = b[4:0];
            else
            begin
                cur_note   = b & NOTE_BITS;
                parse_mask = FULL_CELL_MASK;
            end
        end
        else if (parse_mask[FIELD_NOTE])
        begin
            cur_note = b;
            parse_mask[FIELD_NOTE] = 1'b0;
        end
        else if (parse_mask[FIELD_INST])
        begin
            cur_inst = b;
            parse_mask[FIELD_INST] = 1'b0;
        end
        else if (parse_mask[FIELD_VOL])
        begin
            cur_vol = b;
            parse_mask[FIELD_VOL] = 1'b0;
        end
        else if (parse_mask[FIELD_EFF])
        begin
            cur_eff = b;
            parse_mask[FIELD_EFF] = 1'b0;
        end
        else
        begin
            arg        = b;
            parse_mask = '0;
        end

        if (parse_mask == '0)
        begin
            nch      = eff_count(cfg_channels, DEF_MAX_CHANNELS);
            nrow     = eff_count(cfg_rows, DEF_MAX_ROWS);
            last_ch  = (int'(chan_pos) + 1) >= nch;
            last_row = (int'(row_pos) + 1) >= nrow;
            if (cur_note == NOTE_KEY_OFF_IN)
                due_word.note_value = NOTE_KEY_OFF_OUT;
            else if (cur_note == '0)
                due_word.note_value = '0;
            else
                due_word.note_value = cur_note + NOTE_OFFSET;
            due_word.instrument_number = cur_inst;
            due_word.volume_column     = cur_vol;
            due_word.effect_type       = cur_eff;
            due_word.effect_argument   = arg;
            due_word.channel_index     = chan_pos;
            due_word.row_index         = row_pos;
            due_word.pattern_done      = last_ch && last_row;
            cells_due.push_back(due_word);
            if (last_ch)
            begin
                chan_pos = '0;
                row_pos  = last_row ? 8'd0 : row_pos + 8'd1;
            end
            else
                chan_pos = chan_pos + 5'd1;
            cur_note = '0;
            cur_inst = '0;
            cur_vol  = '0;
            cur_eff  = '0;
        end
    endtask

    function automatic string cell_diff(cell_word_t e, cell_word_t g);
        string s = "";
        if (g.note_value !== e.note_value)
            s = {s, $sformatf(" note %02h/%02h", e.note_value, g.note_value)};
        if (g.instrument_number !== e.instrument_number)
            s = {s, $sformatf(" inst %02h/%02h", e.instrument_number, g.instrument_number)};
        if (g.volume_column !== e.volume_column)
            s = {s, $sformatf(" vol %02h/%02h", e.volume_column, g.volume_column)};
        if (g.effect_type !== e.effect_type)
            s = {s, $sformatf(" eff %02h/%02h", e.effect_type, g.effect_type)};
        if (g.effect_argument !== e.effect_argument)
            s = {s, $sformatf(" arg %02h/%02h", e.effect_argument, g.effect_argument)};
        if (g.channel_index !== e.channel_index)
            s = {s, $sformatf(" chan %0d/%0d", e.channel_index, g.channel_index)};
        if (g.row_index !== e.row_index)
            s = {s, $sformatf(" row %0d/%0d", e.row_index, g.row_index)};
        if (g.pattern_done !== e.pattern_done)
            s = {s, $sformatf(" done %0b/%0b", e.pattern_done, g.pattern_done)};
        return s;
    endfunction

    function automatic logic [7:0] field_byte();
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(3))
                0: return 8'h00;
                1: return 8'hFF;
                2: return NOTE_KEY_OFF_IN;
                default: return 8'h80;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic push_byte(input logic [7:0] b);
        bytes_pending.push_back(b);
        sent_total++;
    endtask

    task automatic queue_random_cell();
        int unsigned pick;
        logic [7:0]  head;
        pick = $urandom_range(99);
        if (pick < 10)
            push_byte(8'($urandom_range(255)));
        else if (pick < 45)
        begin
            push_byte(field_byte() & NOTE_BITS);
            repeat (4) push_byte(field_byte());
        end
        else
        begin
            head = 8'($urandom_range(127));
            head[PACKED_BIT] = 1'b1;
            push_byte(head);
            for (int f = FIELD_NOTE; f <= FIELD_PARAM; f++)
                if (head[f])
                    push_byte(field_byte());
        end
    endtask

    task automatic fill_random(input int unsigned n);
        int unsigned start;
        start = sent_total;
        while (sent_total - start < n)
            queue_random_cell();
    endtask

    // wait until every byte is taken and every cell is out, then let the pipe empty
    task automatic settle();
        while (taken_total != sent_total)
            @(posedge clk);
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_counts(input int unsigned ch, input int unsigned rows);
        apb_write(ADDR_CHANNELS, ch);
        cfg_channels = ch[5:0];
        apb_write(ADDR_ROWS, rows);
        cfg_rows = rows[8:0];
    endtask

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_if.valid <= 1'b0;
            byte_if.data  <= '0;
        end
        else if (!byte_if.valid || byte_if.ready)
        begin
            if (send_hold > 0)
            begin
                send_hold--;
                byte_if.valid <= 1'b0;
            end
            else if (!no_idle && $urandom_range(99) < 3)
            begin
                send_hold = $urandom_range(6);
                byte_if.valid <= 1'b0;
            end
            else if (bytes_pending.size() != 0)
            begin
                byte_if.valid <= 1'b1;
                byte_if.data  <= bytes_pending.pop_front();
            end
            else
                byte_if.valid <= 1'b0;
        end
    end

    // cell sink with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_if.ready <= 1'b0;
        else if (sink_hold > 0)
        begin
            sink_hold--;
            cell_if.ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(99) < 3)
        begin
            sink_hold = $urandom_range(6);
            cell_if.ready <= 1'b0;
        end
        else
            cell_if.ready <= 1'b1;
    end

    // monitor: predict on each byte taken, check each cell word
    always @(posedge clk)
    begin : monitor
        cell_word_t exp_cell;
        string      diff;
        bit         moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (byte_if.valid && byte_if.ready)
            begin
                unpack_byte(byte_if.data.pattern_byte);
                taken_total++;
                moved = 1'b1;
            end
            if (cell_if.valid && cell_if.ready)
            begin
                moved = 1'b1;
                if (cells_due.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("cell %0d: unexpected word %h", cells_seen, cell_if.data);
                end
                else
                begin
                    exp_cell = cells_due.pop_front();
                    diff = cell_diff(exp_cell, cell_if.data);
                    if (diff != "")
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("cell %0d mismatch (expected/actual):%s", cells_seen, diff);
                    end
                end
                cells_seen++;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    // watchdog
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int ch_set   [N_PHASES] = '{1, 0, 32, 63, 3, -1, -1, 8};
        int rows_set [N_PHASES] = '{1, 0, 256, 511, 5, -1, -1, 64};
        int unsigned ch;
        int unsigned rows;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        byte_if.valid = 1'b0;
        byte_if.data  = '0;
        cell_if.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset counts first
        foreach (directed_bytes[i])
            push_byte(directed_bytes[i]);
        fill_random(PHASE_BYTES);
        settle();

        for (int p = 0; p < N_PHASES; p++)
        begin
            ch   = (ch_set[p] < 0) ? $urandom_range(63) : ch_set[p];
            rows = (rows_set[p] < 0) ? $urandom_range(511) : rows_set[p];
            // run one phase at full rate on both sides
            no_idle = (p == 3);
            write_counts(ch, rows);
            fill_random(PHASE_BYTES);
            settle();
        end
        no_idle = 1'b0;

        if (fails == 0 && cells_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
